### hdl/rtbs_pkg.sv
package rtbs_pkg;

   localparam int SLOTS_DEF  = 5;
   localparam int BURSTS_DEF = 3;
   localparam int BURST_W    = 8;
   localparam int RAND_W     = 16;
   localparam int VEC_SLOTS  = 5;
   localparam int VEC_W      = 3 * VEC_SLOTS;
   localparam logic [BURST_W-1:0] CPU_STEP = BURST_W'(1);
   localparam logic [BURST_W-1:0] IO_STEP  = BURST_W'(2);

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_CPU   = 2'd1,
      MODE_SCHED = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_READY    = 3'd0,
      ST_RUNNING  = 3'd1,
      ST_FINISHED = 3'd2,
      ST_IO       = 3'd3,
      ST_EMPTY    = 3'd4
   } slot_st_type;

   typedef struct packed {
      mode_type           mode;
      logic [2:0]         slot;
      logic [BURST_W-1:0] cpu_burst_0;
      logic [BURST_W-1:0] cpu_burst_1;
      logic [BURST_W-1:0] cpu_burst_2;
      logic [BURST_W-1:0] io_burst_0;
      logic [BURST_W-1:0] io_burst_1;
      logic [BURST_W-1:0] io_burst_2;
      logic [RAND_W-1:0]  random_value;
   } req_type;

   typedef struct packed {
      logic             selected_valid;
      logic [2:0]       selected_slot;
      logic [VEC_W-1:0] state_vector;
      logic             any_unfinished;
   } rsp_type;

endpackage

### hdl/random_thread_burst_scheduler.sv
// Thread slot scheduler with random choice among the ready slots.
// An input word is taken at a rising edge where start is high and busy is low;
// busy then stays high until the item is done. Each item gives exactly one
// result word, shown on rsp_word for a single cycle with rsp_strobe high; the
// receiver cannot hold it off and must take it in that cycle.
// A load writes the CPU and IO bursts of its slot phase by phase; a CPU tick
// counts down the CPU burst of the first running slot; a no-operation word
// goes straight to its result. A scheduler tick makes one pass to collect the
// ready set; if it is not empty, a 16-step restoring remainder unit makes the
// random choice and a pass finds the chosen slot. Then a pass runs through the
// IO counters, which sit in single-port memories with registered read data.
// A new item may be started in the cycle in which the previous result shows.
// Reset is synchronous; it marks all slots empty, clears the phases and drops
// busy and the strobe. The burst memories are not cleared: an entry is always
// loaded before its slot can be used.
module random_thread_burst_scheduler #(
   parameter int SLOTS  = rtbs_pkg::SLOTS_DEF,
   parameter int BURSTS = rtbs_pkg::BURSTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rtbs_pkg::req_type req_word,
   output logic             rsp_strobe,
   output rtbs_pkg::rsp_type rsp_word
);
   import rtbs_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PH_W   = (BURSTS > 1) ? $clog2(BURSTS) : 1;
   localparam int DEPTH  = SLOTS * BURSTS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [PH_W-1:0]   LAST_PH   = PH_W'(BURSTS - 1);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_LOAD     = 11'b000_0000_0010,
      S_CPU_SCAN = 11'b000_0000_0100,
      S_CPU_UPD  = 11'b000_0000_1000,
      S_SCAN     = 11'b000_0001_0000,
      S_DIV_GO   = 11'b000_0010_0000,
      S_DIV_WAIT = 11'b000_0100_0000,
      S_SELECT   = 11'b000_1000_0000,
      S_IO_RD    = 11'b001_0000_0000,
      S_IO_UPD   = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } fsm_type;

   fsm_type           fsm_ff, fsm_in;
   slot_st_type       slot_st_ff [SLOTS];
   slot_st_type       slot_st_in [SLOTS];
   logic [PH_W-1:0]   cpu_ph_ff [SLOTS];
   logic [PH_W-1:0]   cpu_ph_in [SLOTS];
   logic [PH_W-1:0]   io_ph_ff [SLOTS];
   logic [PH_W-1:0]   io_ph_in [SLOTS];
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [PH_W-1:0]   bidx_ff, bidx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [SLOTS-1:0]  snap_ff, snap_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic              pick_vld_ff, pick_vld_in;

   logic               cpu_we, cpu_re, io_we, io_re;
   logic [BURST_W-1:0] cpu_wdata, io_wdata, cpu_rdata, io_rdata;
   logic [ADDR_W-1:0]  mem_addr;
   logic [PH_W-1:0]    ph_sel;
   logic [BURST_W-1:0] dec_src, dec_step, dec_val;
   logic [BURST_W-1:0] load_cpu, load_io;
   logic               div_start, div_done;
   logic [CNT_W-1:0]   div_rem;
   logic [VEC_W-1:0]   vec;
   logic               any_unf;

   rtbs_mem #(.DEPTH(DEPTH)) u_cpu_mem (
      .clock   (clock),
      .wr_en   (cpu_we),
      .rd_en   (cpu_re),
      .addr    (mem_addr),
      .wr_data (cpu_wdata),
      .rd_data (cpu_rdata)
   );

   rtbs_mem #(.DEPTH(DEPTH)) u_io_mem (
      .clock   (clock),
      .wr_en   (io_we),
      .rd_en   (io_re),
      .addr    (mem_addr),
      .wr_data (io_wdata),
      .rd_data (io_rdata)
   );

   rtbs_div #(.DIV_W(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ff.random_value),
      .divisor   (cnt_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      if (fsm_ff == S_LOAD) begin
         ph_sel = bidx_ff;
      end else if (fsm_ff == S_IO_RD || fsm_ff == S_IO_UPD) begin
         ph_sel = io_ph_ff[idx_ff];
      end else begin
         ph_sel = cpu_ph_ff[idx_ff];
      end
      mem_addr = ADDR_W'(ADDR_W'(idx_ff) * ADDR_W'(BURSTS)) + ADDR_W'(ph_sel);
   end

   always_comb begin
      case (int'(bidx_ff))
         0: begin
            load_cpu = req_ff.cpu_burst_0;
            load_io  = req_ff.io_burst_0;
         end
         1: begin
            load_cpu = req_ff.cpu_burst_1;
            load_io  = req_ff.io_burst_1;
         end
         2: begin
            load_cpu = req_ff.cpu_burst_2;
            load_io  = req_ff.io_burst_2;
         end
         default: begin
            load_cpu = '0;
            load_io  = '0;
         end
      endcase
   end

   // One saturating subtractor serves both the CPU and the IO countdown.
   always_comb begin
      if (fsm_ff == S_IO_UPD) begin
         dec_src  = io_rdata;
         dec_step = IO_STEP;
      end else begin
         dec_src  = cpu_rdata;
         dec_step = CPU_STEP;
      end
      dec_val = (dec_src > dec_step) ? dec_src - dec_step : '0;
   end

   for (genvar j = 0; j < VEC_SLOTS; j++) begin : g_vec
      if (j < SLOTS) begin : g_used
         assign vec[3*j +: 3] = slot_st_ff[j];
      end else begin : g_unused
         assign vec[3*j +: 3] = '0;
      end
   end

   always_comb begin
      any_unf = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_st_ff[i] != ST_FINISHED) begin
            any_unf = 1'b1;
         end
      end
   end

   always_comb begin
      fsm_in        = fsm_ff;
      slot_st_in    = slot_st_ff;
      cpu_ph_in     = cpu_ph_ff;
      io_ph_in      = io_ph_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      bidx_in       = bidx_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      snap_in       = snap_ff;
      pick_in       = pick_ff;
      pick_vld_in   = pick_vld_ff;
      cpu_we        = 1'b0;
      cpu_re        = 1'b0;
      io_we         = 1'b0;
      io_re         = 1'b0;
      cpu_wdata     = load_cpu;
      io_wdata      = load_io;
      div_start     = 1'b0;

      unique case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_word;
               idx_in      = '0;
               bidx_in     = '0;
               cnt_in      = '0;
               snap_in     = '0;
               pick_in     = '0;
               pick_vld_in = 1'b0;
               unique case (req_word.mode)
                  MODE_LOAD: begin
                     if (int'(req_word.slot) < SLOTS) begin
                        idx_in = SLOT_W'(req_word.slot);
                        fsm_in = S_LOAD;
                     end else begin
                        fsm_in = S_DONE;
                     end
                  end
                  MODE_CPU:   fsm_in = S_CPU_SCAN;
                  MODE_SCHED: fsm_in = S_SCAN;
                  default:    fsm_in = S_DONE;
               endcase
            end
         end
         S_LOAD: begin
            cpu_we = 1'b1;
            io_we  = 1'b1;
            if (bidx_ff == LAST_PH) begin
               slot_st_in[idx_ff] = ST_READY;
               cpu_ph_in[idx_ff]  = '0;
               io_ph_in[idx_ff]   = '0;
               fsm_in             = S_DONE;
            end else begin
               bidx_in = bidx_ff + 1'b1;
            end
         end
         S_CPU_SCAN: begin
            if (slot_st_ff[idx_ff] == ST_RUNNING) begin
               cpu_re = 1'b1;
               fsm_in = S_CPU_UPD;
            end else if (idx_ff == LAST_SLOT) begin
               fsm_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CPU_UPD: begin
            cpu_we    = 1'b1;
            cpu_wdata = dec_val;
            if (dec_val == '0) begin
               slot_st_in[idx_ff] = ST_IO;
               if (cpu_ph_ff[idx_ff] != LAST_PH) begin
                  cpu_ph_in[idx_ff] = cpu_ph_ff[idx_ff] + 1'b1;
               end
            end
            fsm_in = S_DONE;
         end
         S_SCAN: begin
            if (slot_st_ff[idx_ff] == ST_READY) begin
               snap_in[idx_ff] = 1'b1;
               cnt_in          = cnt_ff + 1'b1;
            end else if (slot_st_ff[idx_ff] == ST_RUNNING) begin
               slot_st_in[idx_ff] = ST_READY;
            end
            if (idx_ff == LAST_SLOT) begin
               fsm_in = S_DIV_GO;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DIV_GO: begin
            idx_in  = '0;
            seen_in = '0;
            if (cnt_ff == '0) begin
               fsm_in = S_IO_RD;
            end else begin
               div_start = 1'b1;
               fsm_in    = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               fsm_in = S_SELECT;
            end
         end
         S_SELECT: begin
            idx_in = idx_ff + 1'b1;
            if (snap_ff[idx_ff]) begin
               if (seen_ff == div_rem) begin
                  slot_st_in[idx_ff] = ST_RUNNING;
                  pick_in            = idx_ff;
                  pick_vld_in        = 1'b1;
                  idx_in             = '0;
                  fsm_in             = S_IO_RD;
               end else begin
                  seen_in = seen_ff + 1'b1;
               end
            end
         end
         S_IO_RD: begin
            if (slot_st_ff[idx_ff] == ST_IO) begin
               io_re  = 1'b1;
               fsm_in = S_IO_UPD;
            end else if (idx_ff == LAST_SLOT) begin
               fsm_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IO_UPD: begin
            io_we    = 1'b1;
            io_wdata = dec_val;
            if (dec_val == '0) begin
               if (io_ph_ff[idx_ff] == LAST_PH) begin
                  slot_st_in[idx_ff] = ST_FINISHED;
               end else begin
                  slot_st_in[idx_ff] = ST_READY;
                  io_ph_in[idx_ff]   = io_ph_ff[idx_ff] + 1'b1;
               end
            end
            if (idx_ff == LAST_SLOT) begin
               fsm_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               fsm_in = S_IO_RD;
            end
         end
         S_DONE: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.selected_valid = pick_vld_ff;
            rsp_in.selected_slot  = pick_vld_ff ? 3'(pick_ff) : 3'd0;
            rsp_in.state_vector   = vec;
            rsp_in.any_unfinished = any_unf;
            fsm_in                = S_IDLE;
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_st_ff[i] <= ST_EMPTY;
            cpu_ph_ff[i]  <= '0;
            io_ph_ff[i]   <= '0;
         end
      end else begin
         fsm_ff        <= fsm_in;
         rsp_strobe_ff <= rsp_strobe_in;
         slot_st_ff    <= slot_st_in;
         cpu_ph_ff     <= cpu_ph_in;
         io_ph_ff      <= io_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      bidx_ff     <= bidx_in;
      cnt_ff      <= cnt_in;
      seen_ff     <= seen_in;
      snap_ff     <= snap_in;
      pick_ff     <= pick_in;
      pick_vld_ff <= pick_vld_in;
   end

   assign busy       = (fsm_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

### hdl/rtbs_mem.sv
module rtbs_mem #(
   parameter int DEPTH = rtbs_pkg::SLOTS_DEF * rtbs_pkg::BURSTS_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [rtbs_pkg::BURST_W-1:0] wr_data,
   output logic [rtbs_pkg::BURST_W-1:0] rd_data
);
   import rtbs_pkg::*;

   logic [BURST_W-1:0] mem [DEPTH];
   logic [BURST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rtbs_div.sv
module rtbs_div #(
   parameter int DIV_W = $clog2(rtbs_pkg::SLOTS_DEF + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rtbs_pkg::RAND_W-1:0] dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        done,
   output logic [DIV_W-1:0]            remainder
);
   import rtbs_pkg::*;

   localparam int STEP_W = $clog2(RAND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [RAND_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      div_in    = div_ff;
      trial     = {rem_ff[DIV_W-1:0], num_ff[RAND_W-1]};
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = '0;
         num_in    = dividend;
         div_in    = divisor;
      end else if (active_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         num_in  = {num_ff[RAND_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DIV_W-1:0];

endmodule

### hdl/rtbs_checker.sv
module rtbs_checker #(
   parameter int SLOTS = rtbs_pkg::SLOTS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rtbs_pkg::rsp_type rsp_word
);
   import rtbs_pkg::*;

   // Result strobes never come back to back.
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An accepted word makes the block busy and cannot give its result at once.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted word did not raise busy");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word shown while still busy");

   a_no_pick_slot : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.selected_valid |-> rsp_word.selected_slot == 3'd0)
      else $error("slot number given without a selection");

   // The slot just chosen must show as running in the state vector.
   a_pick_running : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.selected_valid && (SLOTS <= VEC_SLOTS) |->
         rsp_word.state_vector[3*rsp_word.selected_slot +: 3] == ST_RUNNING)
      else $error("selected slot is not running");

endmodule

bind random_thread_burst_scheduler rtbs_checker #(.SLOTS(SLOTS)) u_rtbs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
